@@ design/scti_pkg.sv @@
package scti_pkg;

  // Default widths of the angle and result ports
  localparam int ANGLE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF   = 16;

  // Table entries are unsigned Q1.30, so 1.0 needs 31 bits
  localparam int TBL_W  = 31;
  // Remainder in radians, Q2.30, stays below 10 degrees
  localparam int BRAD_W = 28;
  // Width of the two Q2.60 products and their sum
  localparam int SUM_W  = 62;

  // Degrees to radians, Q2.30
  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

  // Clock edges from an accepting edge to the edge that takes the result
  localparam int SCTI_LATENCY = 9;

  typedef logic [TBL_W-1:0]  tbl_t;
  typedef logic [BRAD_W-1:0] brad_t;
  typedef logic [3:0]        idx_t;

  // Sine at 0..90 degrees in 10 degree steps
  function automatic tbl_t coarse_sin(input idx_t idx);
    tbl_t val;
    case (idx)
      4'd0:    val = 31'd0;
      4'd1:    val = 31'd186453311;
      4'd2:    val = 31'd367241333;
      4'd3:    val = 31'd536870912;
      4'd4:    val = 31'd690187940;
      4'd5:    val = 31'd822533958;
      4'd6:    val = 31'd929887697;
      4'd7:    val = 31'd1008987269;
      4'd8:    val = 31'd1057429273;
      4'd9:    val = 31'd1073741824;
      default: val = 31'd0;
    endcase
    return val;
  endfunction

  // Cosine at 0..9 degrees in 1 degree steps
  function automatic tbl_t fine_cos(input idx_t idx);
    tbl_t val;
    case (idx)
      4'd0:    val = 31'd1073741824;
      4'd1:    val = 31'd1073578288;
      4'd2:    val = 31'd1073087729;
      4'd3:    val = 31'd1072270298;
      4'd4:    val = 31'd1071126243;
      4'd5:    val = 31'd1069655912;
      4'd6:    val = 31'd1067859754;
      4'd7:    val = 31'd1065738315;
      4'd8:    val = 31'd1063292242;
      4'd9:    val = 31'd1060522351;
      default: val = 31'd0;
    endcase
    return val;
  endfunction

  // Whole degrees of the remainder in radians, Q2.30
  function automatic brad_t whole_deg_rad(input idx_t idx);
    return BRAD_W'(idx) * BRAD_W'(DEG_TO_RAD_Q30);
  endfunction

endpackage

@@ design/scti_eval.sv @@
module scti_eval #(
  parameter int ANGLE_BITS = scti_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS   = scti_pkg::OUT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [ANGLE_BITS-1:0] in_ang,
  output logic                  out_vld,
  output logic [OUT_BITS-1:0]   out_val
);
  import scti_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int OB = OUT_BITS;
  localparam int SH = 61 - OB;

  // Stage 1: fold into the first quadrant
  logic            s1_vld_r, s1_neg_r;
  logic [AB-2:0]   s1_ph_r, s1_ph_nxt;
  logic [AB-1:0]   mirror;
  // Stage 2: coarse index and phase in degrees
  logic            s2_vld_r, s2_neg_r;
  idx_t            s2_a_r, s2_a_nxt;
  logic [AB+7:0]   s2_p360_r;
  logic [AB+4:0]   p36;
  logic [AB+7:0]   p360;
  // Stage 3: degree remainder split into whole and fraction
  logic            s3_vld_r, s3_neg_r;
  idx_t            s3_a_r, s3_fidx_r, s3_fidx_nxt;
  logic [AB-1:0]   s3_frac_r;
  logic [AB+7:0]   rem;
  // Stage 4: table reads and fraction to radians
  logic            s4_vld_r, s4_neg_r;
  logic [AB+24:0]  s4_prod_r;
  tbl_t            s4_cs_a_r, s4_fc_r, s4_cs_c_r;
  brad_t           s4_fk_r;
  // Stage 5: first product and rounded remainder in radians
  logic            s5_vld_r, s5_neg_r;
  brad_t           s5_brad_r, s5_brad_nxt;
  logic [SUM_W-1:0] s5_p1_r;
  tbl_t            s5_cs_c_r;
  logic [AB+25:0]  prod_rnd;
  // Stage 6: second product
  logic            s6_vld_r, s6_neg_r;
  logic [SUM_W-1:0] s6_p1_r, s6_p2_r;
  // Stage 7: sum and round to the output scale
  logic            s7_vld_r, s7_neg_r;
  logic [OB:0]     s7_mag_r;
  logic [SUM_W-1:0] sum;
  // Stage 8: clamp and sign
  logic            s8_vld_r;
  logic [OB-1:0]   s8_val_r, s8_val_nxt;
  logic [OB:0]     top_val, mag_c;

  // Mirror a phase past the quarter turn
  always_comb begin
    mirror = {1'b1, {(AB-1){1'b0}}} - {1'b0, in_ang[AB-2:0]};
    if (in_ang[AB-2:0] > {1'b1, {(AB-2){1'b0}}}) begin
      s1_ph_nxt = mirror[AB-2:0];
    end else begin
      s1_ph_nxt = in_ang[AB-2:0];
    end
  end

  // Coarse 10 degree index, clamped at the quarter turn
  always_comb begin
    p36  = (AB+5)'(s1_ph_r) * (AB+5)'(36);
    p360 = (AB+8)'(s1_ph_r) * (AB+8)'(360);
    if (p36[AB+4:AB] > 5'd9) begin
      s2_a_nxt = 4'd9;
    end else begin
      s2_a_nxt = p36[AB+3:AB];
    end
  end

  // Remainder in units of 2^-AB degree
  always_comb begin
    rem = s2_p360_r - (((AB+8)'(s2_a_r) * (AB+8)'(10)) << AB);
    if (rem[AB+3:AB] > 4'd9) begin
      s3_fidx_nxt = 4'd9;
    end else begin
      s3_fidx_nxt = rem[AB+3:AB];
    end
  end

  // Round the fraction product and add the whole degrees
  always_comb begin
    prod_rnd    = (AB+26)'(s4_prod_r) + ((AB+26)'(1) << (AB-1));
    s5_brad_nxt = s4_fk_r + BRAD_W'(prod_rnd[AB+25:AB]);
  end

  // Sum both terms and round half up
  always_comb begin
    sum = s6_p1_r + s6_p2_r + (SUM_W'(1) << (SH-1));
  end

  // Clamp at the largest positive code, then apply the sign
  always_comb begin
    top_val = {2'b00, {(OB-1){1'b1}}};
    mag_c   = (s7_mag_r > top_val) ? top_val : s7_mag_r;
    if (s7_neg_r) begin
      s8_val_nxt = OB'(0) - mag_c[OB-1:0];
    end else begin
      s8_val_nxt = mag_c[OB-1:0];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
    end
  end

  // Advance the data
  always_ff @(posedge clk) begin
    s1_neg_r  <= in_ang[AB-1];
    s1_ph_r   <= s1_ph_nxt;

    s2_neg_r  <= s1_neg_r;
    s2_a_r    <= s2_a_nxt;
    s2_p360_r <= p360;

    s3_neg_r  <= s2_neg_r;
    s3_a_r    <= s2_a_r;
    s3_fidx_r <= s3_fidx_nxt;
    s3_frac_r <= rem[AB-1:0];

    s4_neg_r  <= s3_neg_r;
    s4_prod_r <= (AB+25)'(s3_frac_r) * (AB+25)'(DEG_TO_RAD_Q30);
    s4_cs_a_r <= coarse_sin(s3_a_r);
    s4_fc_r   <= fine_cos(s3_fidx_r);
    s4_cs_c_r <= coarse_sin(4'd9 - s3_a_r);
    s4_fk_r   <= whole_deg_rad(s3_fidx_r);

    s5_neg_r  <= s4_neg_r;
    s5_brad_r <= s5_brad_nxt;
    s5_p1_r   <= SUM_W'(s4_cs_a_r) * SUM_W'(s4_fc_r);
    s5_cs_c_r <= s4_cs_c_r;

    s6_neg_r  <= s5_neg_r;
    s6_p1_r   <= s5_p1_r;
    s6_p2_r   <= SUM_W'(s5_brad_r) * SUM_W'(s5_cs_c_r);

    s7_neg_r  <= s6_neg_r;
    s7_mag_r  <= sum[SUM_W-1:SH];

    s8_val_r  <= s8_val_nxt;
  end

  assign out_vld = s8_vld_r;
  assign out_val = s8_val_r;

endmodule

@@ design/sine_cosine_table_interp_unit.sv @@
// Sine and cosine of a phase by table lookup and angle addition.
//
// Input: drive in_angle (unsigned fraction of one turn) with start high;
// the transaction is taken at the rising edge where start is high and
// busy is low. busy is high only during reset and the cycle after it, so
// a new angle may be taken in every clock cycle.
//
// Output: out_sine and out_cosine (signed Q1.(OUT_BITS-1), magnitude
// saturated at the largest positive code) are shown for one cycle with
// out_valid high; the strobe follows the angle through the input
// register and the eight evaluation stages. Results leave in the
// order the angles came in, one per cycle at full rate.
//
// Latency is set by the eight-stage evaluation pipeline plus the input
// register; the two products of the angle-addition formula sit in
// separate stages. The sine and cosine run in two identical pipelines.
//
// Reset clears all valid bits, so no result strobes after reset until
// new angles arrive. The receiver cannot stall; results are never held.
module sine_cosine_table_interp_unit #(
  parameter int ANGLE_BITS = scti_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS   = scti_pkg::OUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ANGLE_BITS-1:0]      in_angle,
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] out_sine,
  output logic signed [OUT_BITS-1:0] out_cosine
);
  import scti_pkg::*;

  logic                  busy_r;
  logic                  in_vld_r;
  logic [ANGLE_BITS-1:0] ang_sin_r, ang_cos_r;
  logic                  sin_vld, cos_vld;
  logic [OUT_BITS-1:0]   sin_val, cos_val;

  // Hold busy through reset, release right after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= start & ~busy_r;
    end
  end

  // Capture the phase and the phase advanced by a quarter turn
  always_ff @(posedge clk) begin
    ang_sin_r <= in_angle;
    ang_cos_r <= in_angle + (ANGLE_BITS'(1) << (ANGLE_BITS-2));
  end

  scti_eval #(
    .ANGLE_BITS(ANGLE_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld_r),
    .in_ang (ang_sin_r),
    .out_vld(sin_vld),
    .out_val(sin_val)
  );

  scti_eval #(
    .ANGLE_BITS(ANGLE_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld_r),
    .in_ang (ang_cos_r),
    .out_vld(cos_vld),
    .out_val(cos_val)
  );

  assign busy       = busy_r;
  assign out_valid  = sin_vld & cos_vld;
  assign out_sine   = sin_val;
  assign out_cosine = cos_val;

endmodule

@@ design/scti_checker.sv @@
module scti_checker #(
  parameter int ANGLE_BITS = scti_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS   = scti_pkg::OUT_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [ANGLE_BITS-1:0]      in_angle,
  input logic                       out_valid,
  input logic signed [OUT_BITS-1:0] out_sine,
  input logic signed [OUT_BITS-1:0] out_cosine
);
  import scti_pkg::*;

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0] TOP_POS  = {1'b0, {(OUT_BITS-1){1'b1}}};

  // Every accepted transaction strobes a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(SCTI_LATENCY) out_valid)
    else $error("result missing after accepted transaction");

  // No strobe without a transaction accepted at the fixed latency before
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, SCTI_LATENCY))
    else $error("result strobe without a matching transaction");

  // Saturation keeps both outputs off the most negative code
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine != MOST_NEG && out_cosine != MOST_NEG))
    else $error("output holds the most negative code");

  // Zero phase gives zero sine and full-scale cosine
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_angle == '0, SCTI_LATENCY))
      |-> (out_sine == '0 && out_cosine == TOP_POS))
    else $error("wrong result for zero phase");

endmodule

bind sine_cosine_table_interp_unit scti_checker #(
  .ANGLE_BITS(ANGLE_BITS),
  .OUT_BITS  (OUT_BITS)
) u_scti_checker (.*);
